>>> sv/tmss_pkg.sv
// shared types, constants and micro-op table for the transe margin sgd step block
// no dependencies
`default_nettype none

package tmss_pkg;

  // field widths
  localparam int FUNC_W  = 3;
  localparam int ENT_W   = 12;
  localparam int REL_W   = 8;
  localparam int ELEM_W  = 6;
  localparam int VAL_W   = 16;
  localparam int STEP_W  = 15;
  localparam int DIST_W  = 24;
  localparam int DIMS_W  = 7;
  localparam int WBIT_W  = 4;

  // default sizes
  localparam int DEF_MAX_ENTITIES  = 4096;
  localparam int DEF_MAX_RELATIONS = 256;
  localparam int DEF_MAX_DIM       = 64;

  // register reset values
  localparam logic [STEP_W-1:0] STEP_RST   = STEP_W'(41);
  localparam logic [DIST_W-1:0] MARGIN_RST = DIST_W'(4096);
  localparam logic [DIMS_W-1:0] DIMS_RST   = DIMS_W'(64);

  // register indexes
  localparam logic [1:0] REG_STEP   = 2'd0;
  localparam logic [1:0] REG_MARGIN = 2'd1;
  localparam logic [1:0] REG_DIMS   = 2'd2;

  // function codes
  localparam logic [FUNC_W-1:0] F_TRAIN  = 3'd0;
  localparam logic [FUNC_W-1:0] F_INV    = 3'd1;
  localparam logic [FUNC_W-1:0] F_EQU    = 3'd2;
  localparam logic [FUNC_W-1:0] F_WR_ENT = 3'd3;
  localparam logic [FUNC_W-1:0] F_WR_REL = 3'd4;
  localparam logic [FUNC_W-1:0] F_RD_ENT = 3'd5;
  localparam logic [FUNC_W-1:0] F_RD_REL = 3'd6;

  // micro-op kinds
  localparam logic [1:0] K_LOAD = 2'd0;
  localparam logic [1:0] K_SUB  = 2'd1;
  localparam logic [1:0] K_SUBF = 2'd2;
  localparam logic [1:0] K_UPD  = 2'd3;

  // micro-op roles
  localparam logic [1:0] R_H = 2'd0;
  localparam logic [1:0] R_T = 2'd1;
  localparam logic [1:0] R_R = 2'd2;
  localparam logic [1:0] R_P = 2'd3;

  // output selections
  localparam logic [1:0] O_TRAIN  = 2'd0;
  localparam logic [1:0] O_RD_ENT = 2'd1;
  localparam logic [1:0] O_RD_REL = 2'd2;
  localparam logic [1:0] O_ZERO   = 2'd3;

  typedef struct packed {
    logic [1:0] kind;
    logic [1:0] role;
    logic       neg;
    logic       last;
  } uop_t;

  typedef struct packed {
    logic              ld_item;
    logic              wrap;
    logic [WBIT_W-1:0] wbit;
    logic              base_ld;
    logic              clr;
    logic              issue;
    logic              exec;
    logic              upd_phase;
    logic              tri_sel;
    uop_t              op;
    logic              dec;
    logic              item_wr;
    logic              item_rd;
    logic              item_rel;
    logic              out_ld;
    logic [1:0]        out_sel;
  } cmd_t;

  typedef struct packed {
    logic cond;
  } sts_t;

  function automatic uop_t mk(logic [1:0] k, logic [1:0] r, logic n, logic l);
    uop_t u;
    u.kind = k;
    u.role = r;
    u.neg  = n;
    u.last = l;
    return u;
  endfunction

  // per-triple program: distance reads, then the ordered saturating updates
  function automatic uop_t uop_fn(logic phase, logic [FUNC_W-1:0] mode, logic [3:0] pc);
    uop_t u;
    u = mk(K_SUBF, R_R, 1'b0, 1'b1);
    case (pc)
      4'd0: u = mk(K_LOAD, R_T, 1'b0, 1'b0);
      4'd1: u = mk(K_SUB, R_H, 1'b0, 1'b0);
      4'd2: u = mk(K_SUBF, R_R, 1'b0, !phase);
      4'd3: u = mk(K_UPD, R_R, 1'b1, 1'b0);
      4'd4: u = (mode == F_EQU) ? mk(K_UPD, R_P, 1'b1, 1'b0) : mk(K_UPD, R_H, 1'b1, 1'b0);
      4'd5: begin
        if (mode == F_EQU) u = mk(K_UPD, R_H, 1'b1, 1'b0);
        else u = mk(K_UPD, R_T, 1'b0, mode != F_INV);
      end
      4'd6: begin
        if (mode == F_EQU) u = mk(K_UPD, R_T, 1'b0, 1'b1);
        else u = mk(K_UPD, R_P, 1'b1, 1'b0);
      end
      4'd7: u = mk(K_UPD, R_T, 1'b1, 1'b0);
      4'd8: u = mk(K_UPD, R_H, 1'b0, 1'b1);
      default: u = mk(K_SUBF, R_R, 1'b0, 1'b1);
    endcase
    return u;
  endfunction

  function automatic logic signed [VAL_W-1:0] sat16(logic signed [VAL_W+1:0] v);
    if (v > 18'sd32767) return 16'sh7fff;
    if (v < -18'sd32768) return 16'sh8000;
    return v[VAL_W-1:0];
  endfunction

endpackage

`default_nettype wire

>>> sv/tmss_if.sv
// item and result channel interfaces with valid/ready handshake
// depends on tmss_pkg
`default_nettype none

interface tmss_in_if;
  import tmss_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [FUNC_W-1:0]        func;
  logic [ENT_W-1:0]         pos_head;
  logic [ENT_W-1:0]         pos_tail;
  logic [REL_W-1:0]         relation;
  logic [ENT_W-1:0]         neg_head;
  logic [ENT_W-1:0]         neg_tail;
  logic [REL_W-1:0]         partner_relation;
  logic [ELEM_W-1:0]        element_index;
  logic signed [VAL_W-1:0]  element_value;
  modport source (output valid, func, pos_head, pos_tail, relation, neg_head, neg_tail,
                  partner_relation, element_index, element_value, input ready);
  modport sink (input valid, func, pos_head, pos_tail, relation, neg_head, neg_tail,
                partner_relation, element_index, element_value, output ready);
endinterface

interface tmss_out_if;
  import tmss_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [DIST_W-1:0]        loss;
  logic                     updated;
  logic signed [VAL_W-1:0]  read_value;
  modport source (output valid, loss, updated, read_value, input ready);
  modport sink (input valid, loss, updated, read_value, output ready);
endinterface

`default_nettype wire

>>> sv/tmss_ctrl.sv
// controller: sequences index wrap, item access, per-element micro-ops, decision and result beat
// depends on tmss_pkg
`default_nettype none

module tmss_ctrl #(
  parameter int MAX_DIM = tmss_pkg::DEF_MAX_DIM,
  parameter int IW = 6
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  input  wire logic [tmss_pkg::FUNC_W-1:0] in_func,
  input  wire logic [tmss_pkg::ELEM_W-1:0] in_elem,
  output logic                             in_ready,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  input  wire logic [tmss_pkg::DIMS_W-1:0] dims,
  input  wire tmss_pkg::sts_t              sts,
  output tmss_pkg::cmd_t                   cmd,
  output logic [IW-1:0]                    elem
);
  import tmss_pkg::*;

  localparam int NW = $clog2(MAX_DIM + 1);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_WRAP = 4'd1;
  localparam logic [3:0] S_BASE = 4'd2;
  localparam logic [3:0] S_ITEM = 4'd3;
  localparam logic [3:0] S_RD   = 4'd4;
  localparam logic [3:0] S_EX   = 4'd5;
  localparam logic [3:0] S_DEC  = 4'd6;
  localparam logic [3:0] S_OUT  = 4'd7;

  logic [3:0]        state_r, state_nxt;
  logic [WBIT_W-1:0] wcnt_r, wcnt_nxt;
  logic [3:0]        pc_r, pc_nxt;
  logic              tri_r, tri_nxt;
  logic              phase_r, phase_nxt;
  logic [IW-1:0]     elem_r, elem_nxt;
  logic [FUNC_W-1:0] func_r;
  logic              eok_r;
  logic              ov_r, ov_nxt;
  logic [NW-1:0]     n_act;
  logic              is_train;
  logic              last_elem;
  uop_t              op;

  always_comb begin
    if (int'(dims) >= MAX_DIM) n_act = NW'(MAX_DIM);
    else n_act = NW'(dims);
  end

  assign is_train  = func_r inside {F_TRAIN, F_INV, F_EQU};
  assign last_elem = (NW'(elem_r) == n_act - NW'(1));
  assign op        = uop_fn(phase_r, func_r, pc_r);

  always_comb begin
    state_nxt = state_r;
    wcnt_nxt  = wcnt_r;
    pc_nxt    = pc_r;
    tri_nxt   = tri_r;
    phase_nxt = phase_r;
    elem_nxt  = elem_r;
    ov_nxt    = ov_r && !out_ready;
    cmd       = '0;
    cmd.wbit      = wcnt_r;
    cmd.op        = op;
    cmd.tri_sel   = tri_r;
    cmd.upd_phase = phase_r;
    cmd.item_rel  = (func_r == F_WR_REL) || (func_r == F_RD_REL);
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.ld_item = 1'b1;
          wcnt_nxt    = WBIT_W'(ENT_W - 1);
          state_nxt   = S_WRAP;
        end
      end
      S_WRAP: begin
        cmd.wrap = 1'b1;
        if (wcnt_r == '0) state_nxt = S_BASE;
        else wcnt_nxt = wcnt_r - WBIT_W'(1);
      end
      S_BASE: begin
        cmd.base_ld = 1'b1;
        cmd.clr     = 1'b1;
        pc_nxt      = '0;
        tri_nxt     = 1'b0;
        phase_nxt   = 1'b0;
        elem_nxt    = '0;
        if (!is_train) state_nxt = S_ITEM;
        else if (n_act == '0) state_nxt = S_DEC;
        else state_nxt = S_RD;
      end
      S_ITEM: begin
        cmd.item_wr = eok_r && ((func_r == F_WR_ENT) || (func_r == F_WR_REL));
        cmd.item_rd = eok_r && ((func_r == F_RD_ENT) || (func_r == F_RD_REL));
        state_nxt   = S_OUT;
      end
      S_RD: begin
        cmd.issue = 1'b1;
        state_nxt = S_EX;
      end
      S_EX: begin
        cmd.exec  = 1'b1;
        state_nxt = S_RD;
        if (!op.last) begin
          pc_nxt = pc_r + 4'd1;
        end else if (!tri_r) begin
          pc_nxt  = '0;
          tri_nxt = 1'b1;
        end else begin
          pc_nxt  = '0;
          tri_nxt = 1'b0;
          if (last_elem) begin
            elem_nxt  = '0;
            state_nxt = phase_r ? S_OUT : S_DEC;
          end else begin
            elem_nxt = elem_r + IW'(1);
          end
        end
      end
      S_DEC: begin
        cmd.dec = 1'b1;
        if (sts.cond && n_act != '0) begin
          phase_nxt = 1'b1;
          state_nxt = S_RD;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!ov_r || out_ready) begin
          cmd.out_ld = 1'b1;
          ov_nxt     = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    if (is_train) cmd.out_sel = O_TRAIN;
    else if (eok_r && func_r == F_RD_ENT) cmd.out_sel = O_RD_ENT;
    else if (eok_r && func_r == F_RD_REL) cmd.out_sel = O_RD_REL;
    else cmd.out_sel = O_ZERO;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      wcnt_r  <= '0;
      pc_r    <= '0;
      tri_r   <= 1'b0;
      phase_r <= 1'b0;
      elem_r  <= '0;
      ov_r    <= 1'b0;
      func_r  <= F_TRAIN;
      eok_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      wcnt_r  <= wcnt_nxt;
      pc_r    <= pc_nxt;
      tri_r   <= tri_nxt;
      phase_r <= phase_nxt;
      elem_r  <= elem_nxt;
      ov_r    <= ov_nxt;
      if (state_r == S_IDLE && in_valid) begin
        func_r <= in_func;
        eok_r  <= int'(in_elem) < MAX_DIM;
      end
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = ov_r;
  assign elem      = elem_r;

`ifndef NO_ASSERTIONS
  a_wrap_exit: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_WRAP |=> state_r == S_WRAP || state_r == S_BASE)
    else $error("wrap left to wrong state");
  a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> pc_r == '0 && !tri_r)
    else $error("sequencer not reset at idle");
  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_ld |=> out_valid && state_r == S_IDLE)
    else $error("result load did not raise valid");
  a_elem_range: assert property (@(posedge clk) disable iff (!rst_n)
    int'(elem_r) < MAX_DIM)
    else $error("element counter out of range");
`endif

endmodule

`default_nettype wire

>>> sv/tmss_dp.sv
// datapath: embedding memories, index wrap lanes, distance and step arithmetic
// depends on tmss_pkg
`default_nettype none

module tmss_dp #(
  parameter int MAX_ENTITIES  = tmss_pkg::DEF_MAX_ENTITIES,
  parameter int MAX_RELATIONS = tmss_pkg::DEF_MAX_RELATIONS,
  parameter int MAX_DIM       = tmss_pkg::DEF_MAX_DIM,
  parameter int IW = 6
) (
  input  wire logic                               clk,
  input  wire tmss_pkg::cmd_t                     cmd,
  input  wire logic [IW-1:0]                      elem,
  output tmss_pkg::sts_t                          sts,
  input  wire logic [tmss_pkg::STEP_W-1:0]        step_size,
  input  wire logic [tmss_pkg::DIST_W-1:0]        margin,
  input  wire logic [tmss_pkg::ENT_W-1:0]         pos_head,
  input  wire logic [tmss_pkg::ENT_W-1:0]         pos_tail,
  input  wire logic [tmss_pkg::REL_W-1:0]         relation,
  input  wire logic [tmss_pkg::ENT_W-1:0]         neg_head,
  input  wire logic [tmss_pkg::ENT_W-1:0]         neg_tail,
  input  wire logic [tmss_pkg::REL_W-1:0]         partner_relation,
  input  wire logic [tmss_pkg::ELEM_W-1:0]        element_index,
  input  wire logic signed [tmss_pkg::VAL_W-1:0]  element_value,
  output logic [tmss_pkg::DIST_W-1:0]             loss,
  output logic                                    updated,
  output logic signed [tmss_pkg::VAL_W-1:0]       read_value
);
  import tmss_pkg::*;

  localparam int ERW  = (MAX_ENTITIES > 2) ? $clog2(MAX_ENTITIES) : 1;
  localparam int RRW  = (MAX_RELATIONS > 2) ? $clog2(MAX_RELATIONS) : 1;
  localparam int ERW1 = ERW + 1;
  localparam int RRW1 = RRW + 1;
  localparam int EDEP = MAX_ENTITIES * MAX_DIM;
  localparam int RDEP = MAX_RELATIONS * MAX_DIM;
  localparam int EAW  = (EDEP > 2) ? $clog2(EDEP) : 1;
  localparam int RAW  = (RDEP > 2) ? $clog2(RDEP) : 1;
  localparam int DW   = VAL_W + 2;

  logic signed [VAL_W-1:0] ent_mem [EDEP];
  logic signed [VAL_W-1:0] rel_mem [RDEP];

  logic [ENT_W-1:0]  eidx_r [4];
  logic [ENT_W-1:0]  ridx_r [2];
  logic [ERW-1:0]    erem_r [4];
  logic [RRW-1:0]    rrem_r [2];
  logic [EAW-1:0]    ebase_r [4];
  logic [RAW-1:0]    rbase_r [2];
  logic [ELEM_W-1:0] item_elem_r;
  logic signed [VAL_W-1:0] item_val_r;

  logic signed [VAL_W-1:0] ent_q_r, rel_q_r;
  logic signed [DW-1:0]    d_r;
  logic [DIST_W-1:0]       dist_r [2];
  logic                    xneg_r;
  logic [DIST_W-1:0]       loss_r;
  logic                    upd_r;
  logic [DIST_W-1:0]       out_loss_r;
  logic                    out_upd_r;
  logic signed [VAL_W-1:0] out_rv_r;

  function automatic logic [ERW-1:0] emod(logic [ERW-1:0] r, logic b);
    logic [ERW1-1:0] s;
    s = {r, b};
    if (int'(s) >= MAX_ENTITIES) s = s - ERW1'(MAX_ENTITIES);
    return s[ERW-1:0];
  endfunction

  function automatic logic [RRW-1:0] rmod(logic [RRW-1:0] r, logic b);
    logic [RRW1-1:0] s;
    s = {r, b};
    if (int'(s) >= MAX_RELATIONS) s = s - RRW1'(MAX_RELATIONS);
    return s[RRW-1:0];
  endfunction

  // operand addressing
  logic [1:0]           esel;
  logic                 op_rel;
  logic [EAW-1:0]       op_eaddr, item_eaddr, ent_addr;
  logic [RAW-1:0]       op_raddr, item_raddr, rel_addr;
  logic signed [VAL_W-1:0] val;
  logic signed [DW-1:0] dnew;
  logic signed [DW-1:0] dmag;
  logic [DW-2:0]        dabs;
  logic [DIST_W:0]      dsum;
  logic                 dgt;
  logic                 dec_neg;
  logic signed [DW-1:0] upd_v;
  logic signed [VAL_W-1:0] wval;
  logic [DIST_W:0]      lhs, ldiff;
  logic                 ent_we, rel_we, ent_re, rel_re;
  logic signed [VAL_W-1:0] ent_wd, rel_wd;

  always_comb begin
    esel = {cmd.tri_sel, cmd.op.role == R_T};
    op_rel = (cmd.op.role == R_R) || (cmd.op.role == R_P);
    op_eaddr = ebase_r[esel] + EAW'(elem);
    op_raddr = ((cmd.op.role == R_P) ? rbase_r[1] : rbase_r[0]) + RAW'(elem);
    item_eaddr = ebase_r[0] + EAW'(item_elem_r);
    item_raddr = rbase_r[0] + RAW'(item_elem_r);
    ent_addr = (cmd.item_wr || cmd.item_rd) ? item_eaddr : op_eaddr;
    rel_addr = (cmd.item_wr || cmd.item_rd) ? item_raddr : op_raddr;

    val  = op_rel ? rel_q_r : ent_q_r;
    dnew = d_r - DW'(val);
    dmag = -dnew;
    dabs = dnew[DW-1] ? dmag[DW-2:0] : dnew[DW-2:0];
    dsum = {1'b0, dist_r[cmd.tri_sel]} + (DIST_W + 1)'(dabs);
    dgt  = !dnew[DW-1] && (dnew != '0);

    dec_neg = cmd.op.neg ^ xneg_r;
    upd_v = dec_neg ? (DW'(val) - DW'(step_size)) : (DW'(val) + DW'(step_size));
    wval  = sat16(upd_v);

    lhs   = (DIST_W + 1)'(dist_r[0]) + (DIST_W + 1)'(margin);
    ldiff = lhs - (DIST_W + 1)'(dist_r[1]);
    sts.cond = lhs > (DIST_W + 1)'(dist_r[1]);

    ent_re = (cmd.issue && !op_rel) || (cmd.item_rd && !cmd.item_rel);
    rel_re = (cmd.issue && op_rel) || (cmd.item_rd && cmd.item_rel);
    ent_we = (cmd.exec && cmd.op.kind == K_UPD && !op_rel) || (cmd.item_wr && !cmd.item_rel);
    rel_we = (cmd.exec && cmd.op.kind == K_UPD && op_rel) || (cmd.item_wr && cmd.item_rel);
    ent_wd = cmd.item_wr ? item_val_r : wval;
    rel_wd = cmd.item_wr ? item_val_r : wval;
  end

  // memories, registered read
  always_ff @(posedge clk) begin
    if (ent_we) ent_mem[ent_addr] <= ent_wd;
    if (ent_re) ent_q_r <= ent_mem[ent_addr];
  end

  always_ff @(posedge clk) begin
    if (rel_we) rel_mem[rel_addr] <= rel_wd;
    if (rel_re) rel_q_r <= rel_mem[rel_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_item) begin
      eidx_r[0]   <= pos_head;
      eidx_r[1]   <= pos_tail;
      eidx_r[2]   <= neg_head;
      eidx_r[3]   <= neg_tail;
      ridx_r[0]   <= ENT_W'(relation);
      ridx_r[1]   <= ENT_W'(partner_relation);
      item_elem_r <= element_index;
      item_val_r  <= element_value;
      for (int i = 0; i < 4; i++) erem_r[i] <= '0;
      for (int i = 0; i < 2; i++) rrem_r[i] <= '0;
    end
    if (cmd.wrap) begin
      for (int i = 0; i < 4; i++) erem_r[i] <= emod(erem_r[i], eidx_r[i][cmd.wbit]);
      for (int i = 0; i < 2; i++) rrem_r[i] <= rmod(rrem_r[i], ridx_r[i][cmd.wbit]);
    end
    if (cmd.base_ld) begin
      for (int i = 0; i < 4; i++) ebase_r[i] <= EAW'(erem_r[i]) * EAW'(MAX_DIM);
      for (int i = 0; i < 2; i++) rbase_r[i] <= RAW'(rrem_r[i]) * RAW'(MAX_DIM);
    end
    if (cmd.clr) begin
      dist_r[0] <= '0;
      dist_r[1] <= '0;
      loss_r    <= '0;
      upd_r     <= 1'b0;
    end
    if (cmd.exec) begin
      case (cmd.op.kind)
        K_LOAD: d_r <= DW'(val);
        K_SUB:  d_r <= dnew;
        K_SUBF: begin
          if (cmd.upd_phase) xneg_r <= dgt ^ cmd.tri_sel;
          else dist_r[cmd.tri_sel] <= dsum[DIST_W] ? '1 : dsum[DIST_W-1:0];
        end
        default: d_r <= d_r;
      endcase
    end
    if (cmd.dec) begin
      upd_r  <= sts.cond;
      loss_r <= !sts.cond ? '0 : (ldiff[DIST_W] ? '1 : ldiff[DIST_W-1:0]);
    end
    if (cmd.out_ld) begin
      out_loss_r <= (cmd.out_sel == O_TRAIN) ? loss_r : '0;
      out_upd_r  <= (cmd.out_sel == O_TRAIN) && upd_r;
      case (cmd.out_sel)
        O_RD_ENT: out_rv_r <= ent_q_r;
        O_RD_REL: out_rv_r <= rel_q_r;
        default:  out_rv_r <= '0;
      endcase
    end
  end

  assign loss       = out_loss_r;
  assign updated    = out_upd_r;
  assign read_value = out_rv_r;

endmodule

`default_nettype wire

>>> sv/transe_margin_sgd_step_core.sv
// top level: apb register file, controller and datapath for the margin sgd step
// depends on tmss_pkg, tmss_if, tmss_ctrl, tmss_dp
`default_nettype none

// sequence: item accept, index wrap, a base load, then for each memory micro-op a read slot
//   and a read-modify-write slot, a decision step and the result beat
// training: distance micro-ops for every element in use; a stepped item adds the update
//   micro-ops of its mode (plain, equivalent or inverse), on the single memory port per table
// write/read items: one item in flight, result beat held in an output register
// reset: synchronous active-low rst_n clears control and registers; tables are not cleared
module transe_margin_sgd_step_core #(
  parameter int MAX_ENTITIES  = tmss_pkg::DEF_MAX_ENTITIES,
  parameter int MAX_RELATIONS = tmss_pkg::DEF_MAX_RELATIONS,
  parameter int MAX_DIM       = tmss_pkg::DEF_MAX_DIM
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  tmss_in_if.sink          in_ch,
  tmss_out_if.source       out_ch,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import tmss_pkg::*;

  // element index width
  localparam int IW = (MAX_DIM > 2) ? $clog2(MAX_DIM) : 1;

  logic [STEP_W-1:0] step_r;
  logic [DIST_W-1:0] margin_r;
  logic [DIMS_W-1:0] dims_r;
  logic              wr_beat;
  cmd_t              cmd;
  sts_t              sts;
  logic [IW-1:0]     elem;

  // apb writes complete in the access phase, no wait states
  assign pready  = 1'b1;
  assign wr_beat = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r   <= STEP_RST;
      margin_r <= MARGIN_RST;
      dims_r   <= DIMS_RST;
    end else if (wr_beat) begin
      case (paddr[3:2])
        REG_STEP:   step_r   <= pwdata[STEP_W-1:0];
        REG_MARGIN: margin_r <= pwdata[DIST_W-1:0];
        REG_DIMS:   dims_r   <= pwdata[DIMS_W-1:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_STEP:   prdata = 32'(step_r);
      REG_MARGIN: prdata = 32'(margin_r);
      REG_DIMS:   prdata = 32'(dims_r);
      default:    prdata = '0;
    endcase
  end

  // sequencer
  tmss_ctrl #(.MAX_DIM(MAX_DIM), .IW(IW)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_func   (in_ch.func),
    .in_elem   (in_ch.element_index),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .dims      (dims_r),
    .sts       (sts),
    .cmd       (cmd),
    .elem      (elem)
  );

  // tables and arithmetic
  tmss_dp #(
    .MAX_ENTITIES  (MAX_ENTITIES),
    .MAX_RELATIONS (MAX_RELATIONS),
    .MAX_DIM       (MAX_DIM),
    .IW            (IW)
  ) u_dp (
    .clk              (clk),
    .cmd              (cmd),
    .elem             (elem),
    .sts              (sts),
    .step_size        (step_r),
    .margin           (margin_r),
    .pos_head         (in_ch.pos_head),
    .pos_tail         (in_ch.pos_tail),
    .relation         (in_ch.relation),
    .neg_head         (in_ch.neg_head),
    .neg_tail         (in_ch.neg_tail),
    .partner_relation (in_ch.partner_relation),
    .element_index    (in_ch.element_index),
    .element_value    (in_ch.element_value),
    .loss             (out_ch.loss),
    .updated          (out_ch.updated),
    .read_value       (out_ch.read_value)
  );

endmodule

`default_nettype wire

>>> tb/sv/transe_margin_sgd_step_core_tb.sv
// self-checking testbench for transe_margin_sgd_step_core: pool load, directed table, then random phases
// depends on tmss_pkg, tmss_if and the block's rtl
`default_nettype none

module transe_margin_sgd_step_core_tb;
  import tmss_pkg::*;

  localparam int DIM = DEF_MAX_DIM;
  localparam int CYCLE_LIMIT = 20000000;

  typedef struct {
    logic [FUNC_W-1:0]       func;
    logic [ENT_W-1:0]        ph, pt;
    logic [REL_W-1:0]        rel;
    logic [ENT_W-1:0]        nh, nt;
    logic [REL_W-1:0]        pr;
    logic [ELEM_W-1:0]       ei;
    logic signed [VAL_W-1:0] ev;
  } train_item_t;

  typedef struct {
    logic [DIST_W-1:0]       loss;
    logic                    upd;
    logic signed [VAL_W-1:0] rv;
  } step_result_t;

  typedef struct {
    train_item_t  it;
    bit           typed;
    step_result_t res;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  tmss_in_if  in_bus();
  tmss_out_if out_bus();

  transe_margin_sgd_step_core i_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_bus), .out_ch(out_bus),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // predictor copy of tables and registers
  logic signed [VAL_W-1:0] ent_mem [int];
  logic signed [VAL_W-1:0] rel_mem [int];
  logic [STEP_W-1:0] alpha_q;
  logic [DIST_W-1:0] margin_q;
  logic [DIMS_W-1:0] dims_q;

  // keys of table elements that have been written, so reads stay legal
  int ent_keys[$];
  int rel_keys[$];

  step_result_t loss_fifo[$];
  stim_row_t table_rows[$];
  int errors = 0;
  int cycles = 0;
  int sent = 0;
  bit calm = 1'b0;   // no idling while set

  int ent_pool[4] = '{0, 1, 2, 4095};
  int rel_pool[3] = '{0, 1, 255};

  function automatic void queue_result(step_result_t r);
    loss_fifo.insert(loss_fifo.size(), r);
  endfunction

  function automatic void add_row(stim_row_t s);
    table_rows.insert(table_rows.size(), s);
  endfunction

  function automatic int sat_q(int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic int live_dims();
    return (dims_q > DIM) ? DIM : int'(dims_q);
  endfunction

  function automatic int l1_of(int h, int t, int r);
    int acc;
    int d;
    acc = 0;
    for (int i = 0; i < live_dims(); i++) begin
      d = int'(ent_mem[t*DIM+i]) - int'(ent_mem[h*DIM+i]) - int'(rel_mem[r*DIM+i]);
      acc += (d < 0) ? -d : d;
      if (acc > 16777215) acc = 16777215;
    end
    return acc;
  endfunction

  function automatic void bump_ent(int k, int delta);
    ent_mem[k] = 16'(sat_q(int'(ent_mem[k]) + delta));
  endfunction

  function automatic void bump_rel(int k, int delta);
    rel_mem[k] = 16'(sat_q(int'(rel_mem[k]) + delta));
  endfunction

  // one element of one triple, in the block's update order
  function automatic void sgd_elem(int h, int t, int r, int p, int i, bit pos,
                                   logic [FUNC_W-1:0] mode);
    int a;
    int d;
    int x;
    a = int'(alpha_q);
    d = int'(ent_mem[t*DIM+i]) - int'(ent_mem[h*DIM+i]) - int'(rel_mem[r*DIM+i]);
    if (pos) x = (d > 0) ? -a : a;
    else x = (d > 0) ? a : -a;
    bump_rel(r*DIM+i, -x);
    if (mode == F_EQU) bump_rel(p*DIM+i, -x);
    bump_ent(h*DIM+i, -x);
    bump_ent(t*DIM+i, x);
    if (mode == F_INV) begin
      bump_rel(p*DIM+i, -x);
      bump_ent(t*DIM+i, -x);
      bump_ent(h*DIM+i, x);
    end
  endfunction

  function automatic step_result_t predict_step(train_item_t it);
    step_result_t res;
    int dp;
    int dn;
    longint lhs;
    res = '{loss: '0, upd: 1'b0, rv: '0};
    if (it.func <= F_EQU) begin
      dp = l1_of(it.ph, it.pt, it.rel);
      dn = l1_of(it.nh, it.nt, it.rel);
      lhs = longint'(dp) + longint'(margin_q);
      if (lhs > dn) begin
        res.loss = (lhs - dn > 16777215) ? 24'hffffff : 24'(lhs - dn);
        res.upd = 1'b1;
        for (int i = 0; i < live_dims(); i++) begin
          sgd_elem(it.ph, it.pt, it.rel, it.pr, i, 1'b1, it.func);
          sgd_elem(it.nh, it.nt, it.rel, it.pr, i, 1'b0, it.func);
        end
      end
    end else if (it.func == F_WR_ENT) begin
      if (!ent_mem.exists(it.ph*DIM+it.ei)) ent_keys.insert(ent_keys.size(), it.ph*DIM+it.ei);
      ent_mem[it.ph*DIM+it.ei] = it.ev;
    end else if (it.func == F_WR_REL) begin
      if (!rel_mem.exists(it.rel*DIM+it.ei))
        rel_keys.insert(rel_keys.size(), it.rel*DIM+it.ei);
      rel_mem[it.rel*DIM+it.ei] = it.ev;
    end else if (it.func == F_RD_ENT) begin
      res.rv = ent_mem[it.ph*DIM+it.ei];
    end else if (it.func == F_RD_REL) begin
      res.rv = rel_mem[it.rel*DIM+it.ei];
    end
    return res;
  endfunction

  // present one beat, hold it until accepted
  task automatic push_item(train_item_t it);
    if (!calm && $urandom_range(0, 99) < 14) begin
      in_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_bus.valid            <= 1'b1;
    in_bus.func             <= it.func;
    in_bus.pos_head         <= it.ph;
    in_bus.pos_tail         <= it.pt;
    in_bus.relation         <= it.rel;
    in_bus.neg_head         <= it.nh;
    in_bus.neg_tail         <= it.nt;
    in_bus.partner_relation <= it.pr;
    in_bus.element_index    <= it.ei;
    in_bus.element_value    <= it.ev;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    sent++;
  endtask

  task automatic issue(train_item_t it);
    queue_result(predict_step(it));
    push_item(it);
  endtask

  // idle the input side and wait for the result queue to drain
  task automatic drain();
    @(posedge clk);
    in_bus.valid <= 1'b0;
    while (loss_fifo.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // apb write: setup, then access
  task automatic reg_write(logic [1:0] idx, logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_STEP:   alpha_q  = val[STEP_W-1:0];
      REG_MARGIN: margin_q = val[DIST_W-1:0];
      REG_DIMS:   dims_q   = val[DIMS_W-1:0];
      default: ;
    endcase
  endtask

  function automatic train_item_t blank_item(logic [FUNC_W-1:0] f);
    train_item_t it;
    it.func = f;
    it.ph = $urandom; it.pt = $urandom; it.rel = $urandom; it.nh = $urandom;
    it.nt = $urandom; it.pr = $urandom; it.ei = $urandom; it.ev = $urandom;
    return it;
  endfunction

  function automatic stim_row_t row(logic [FUNC_W-1:0] f, int ph, int pt, int rel,
                                    int nh, int nt, int pr, int ei, int ev, bit typed,
                                    int loss = 0, int upd = 0, int rv = 0);
    stim_row_t s;
    s.it = '{func: f, ph: ph, pt: pt, rel: rel, nh: nh, nt: nt, pr: pr, ei: ei, ev: ev};
    s.typed = typed;
    s.res = '{loss: loss, upd: upd, rv: rv};
    return s;
  endfunction

  // random item: training over the fully written pool, loads anywhere, reads of written keys, unused func
  function automatic train_item_t rand_item();
    train_item_t it;
    int pick;
    int k;
    pick = $urandom_range(0, 99);
    if (pick < 60) begin
      it = blank_item(3'($urandom_range(0, 2)));
      it.ph = ent_pool[$urandom_range(0, 3)];
      it.pt = ent_pool[$urandom_range(0, 3)];
      it.nh = ent_pool[$urandom_range(0, 3)];
      it.nt = ent_pool[$urandom_range(0, 3)];
      it.rel = rel_pool[$urandom_range(0, 2)];
      it.pr = rel_pool[$urandom_range(0, 2)];
    end else if (pick < 75) begin
      it = blank_item($urandom_range(0, 1) ? F_WR_ENT : F_WR_REL);
      if ($urandom_range(0, 1)) begin
        it.ph = ent_pool[$urandom_range(0, 3)];
        it.rel = rel_pool[$urandom_range(0, 2)];
      end
    end else if (pick < 95) begin
      it = blank_item($urandom_range(0, 1) ? F_RD_ENT : F_RD_REL);
      if (it.func == F_RD_ENT) begin
        k = ent_keys[$urandom_range(0, ent_keys.size()-1)];
        it.ph = k / DIM; it.ei = k % DIM;
      end else begin
        k = rel_keys[$urandom_range(0, rel_keys.size()-1)];
        it.rel = k / DIM; it.ei = k % DIM;
      end
    end else begin
      it = blank_item(3'd7);
    end
    return it;
  endfunction

  // result side: check each beat against the oldest expectation, then drive ready at random, high while calm
  always @(posedge clk) begin
    step_result_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (loss_fifo.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result beat loss=%0d", out_bus.loss);
      end else begin
        want = loss_fifo.pop_front();
        if (out_bus.loss !== want.loss || out_bus.updated !== want.upd ||
            out_bus.read_value !== want.rv) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: exp loss=%0d upd=%0d rd=%0d got loss=%0d upd=%0d rd=%0d",
                     want.loss, want.upd, want.rv,
                     out_bus.loss, out_bus.updated, out_bus.read_value);
        end
      end
    end
    out_bus.ready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 14);
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    train_item_t it;
    step_result_t got;
    int phase_cnt[5] = '{150, 150, 110, 140, 34};

    in_bus.valid = 1'b0;
    in_bus.func = '0; in_bus.pos_head = '0; in_bus.pos_tail = '0; in_bus.relation = '0;
    in_bus.neg_head = '0; in_bus.neg_tail = '0; in_bus.partner_relation = '0;
    in_bus.element_index = '0; in_bus.element_value = '0;
    out_bus.ready = 1'b0;
    alpha_q = STEP_RST; margin_q = MARGIN_RST; dims_q = DIMS_RST;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // load every element of the training pool so training never reads unwritten data
    foreach (ent_pool[e])
      for (int i = 0; i < DIM; i++) begin
        it = blank_item(F_WR_ENT); it.ph = ent_pool[e]; it.ei = i;
        issue(it);
      end
    foreach (rel_pool[r])
      for (int i = 0; i < DIM; i++) begin
        it = blank_item(F_WR_REL); it.rel = rel_pool[r]; it.ei = i;
        issue(it);
      end

    // directed rows: value extremes, top indices, unused func, all training modes
    add_row(row(F_WR_ENT, 0, 0, 0, 0, 0, 0, 0, -32768, 1));
    add_row(row(F_RD_ENT, 0, 4095, 255, 4095, 4095, 255, 0, 32767, 1, 0, 0, -32768));
    add_row(row(F_WR_ENT, 4095, 4095, 255, 4095, 4095, 255, 63, 32767, 1));
    add_row(row(F_RD_ENT, 4095, 0, 0, 0, 0, 0, 63, 0, 1, 0, 0, 32767));
    add_row(row(F_WR_REL, 4095, 0, 255, 0, 0, 0, 63, -1, 1));
    add_row(row(F_RD_REL, 0, 0, 255, 0, 0, 0, 63, 0, 1, 0, 0, -1));
    add_row(row(F_WR_REL, 0, 0, 0, 0, 0, 0, 0, 32767, 1));
    add_row(row(F_RD_REL, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 32767));
    add_row(row(F_WR_ENT, 2048, 0, 0, 0, 0, 0, 32, 16'h1234, 1));
    add_row(row(F_RD_ENT, 2048, 0, 0, 0, 0, 0, 32, 0, 1, 0, 0, 16'h1234));
    add_row(row(3'd7, 4095, 4095, 255, 4095, 4095, 255, 63, -1, 1));
    add_row(row(3'd7, 0, 0, 0, 0, 0, 0, 0, 0, 1));
    add_row(row(F_TRAIN, 0, 1, 0, 2, 4095, 1, 0, 0, 0));
    add_row(row(F_INV, 1, 2, 255, 0, 4095, 0, 0, 0, 0));
    add_row(row(F_EQU, 2, 4095, 1, 1, 0, 255, 0, 0, 0));
    // aliased triples: head equals tail, partner equals relation
    add_row(row(F_INV, 0, 0, 1, 0, 0, 1, 0, 0, 0));
    add_row(row(F_EQU, 4095, 4095, 0, 1, 1, 0, 0, 0, 0));
    add_row(row(F_RD_ENT, 0, 0, 0, 0, 0, 0, 5, 0, 0));
    foreach (table_rows[n]) begin
      got = predict_step(table_rows[n].it);
      queue_result(table_rows[n].typed ? table_rows[n].res : got);
      push_item(table_rows[n].it);
    end

    // random phases, each with its own register setting; sender drains in between
    for (int ph = 0; ph < 5; ph++) begin
      drain();
      case (ph)
        0: begin reg_write(REG_STEP, 0);     reg_write(REG_MARGIN, 0);
                 reg_write(REG_DIMS, 1); end
        1: begin reg_write(REG_STEP, 32767); reg_write(REG_MARGIN, 24'hffffff);
                 reg_write(REG_DIMS, 8); end
        2: begin reg_write(REG_STEP, $urandom); reg_write(REG_MARGIN, $urandom);
                 reg_write(REG_DIMS, 0); end
        3: begin reg_write(REG_STEP, 41);    reg_write(REG_MARGIN, $urandom_range(0, 200000));
                 reg_write(REG_DIMS, 4); end
        default: begin reg_write(REG_STEP, 1000); reg_write(REG_MARGIN, 8192);
                 reg_write(REG_DIMS, 127); end
      endcase
      for (int n = 0; n < phase_cnt[ph]; n++) begin
        calm = (ph == 1 && n >= 50 && n < 150);
        issue(rand_item());
      end
      calm = 1'b0;
    end

    drain();
    repeat (50) @(posedge clk);
    if (errors == 0 && loss_fifo.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
